// ===== rtl/core/ssn8_pkg.sv =====
// ----------------------------------------------------------------------------
// ssn8_pkg
// Shared types and the comparator schedule of the eight-lane sorting network.
// ----------------------------------------------------------------------------
`default_nettype none

package ssn8_pkg;

  localparam int NUM_LANES  = 8;
  localparam int LANE_IDX_W = 3;
  localparam int NUM_LAYERS = 6;
  localparam int MAX_CMP    = 4;
  localparam int COUNT_W    = 4;

  typedef logic [1:0] mode_t;

  localparam mode_t MODE_PASS = 2'd0;
  localparam mode_t MODE_NET2 = 2'd1;
  localparam mode_t MODE_NET4 = 2'd2;
  localparam mode_t MODE_NET8 = 2'd3;

  typedef struct packed {
    logic  valid;
    mode_t mode;
  } ctl_t;

  // A comparator is active when en is set and the request's mode is at least min_mode.
  typedef struct packed {
    logic                  en;
    logic [LANE_IDX_W-1:0] lo;
    logic [LANE_IDX_W-1:0] hi;
    mode_t                 min_mode;
  } cmp_t;

  localparam cmp_t LAYER_CMP [NUM_LAYERS][MAX_CMP] = '{
    '{'{1'b1, 3'd0, 3'd1, MODE_NET2}, '{1'b1, 3'd2, 3'd3, MODE_NET4},
      '{1'b1, 3'd4, 3'd5, MODE_NET8}, '{1'b1, 3'd6, 3'd7, MODE_NET8}},
    '{'{1'b1, 3'd0, 3'd2, MODE_NET4}, '{1'b1, 3'd1, 3'd3, MODE_NET4},
      '{1'b1, 3'd4, 3'd6, MODE_NET8}, '{1'b1, 3'd5, 3'd7, MODE_NET8}},
    '{'{1'b1, 3'd1, 3'd2, MODE_NET4}, '{1'b1, 3'd5, 3'd6, MODE_NET8},
      '{1'b1, 3'd0, 3'd4, MODE_NET8}, '{1'b1, 3'd3, 3'd7, MODE_NET8}},
    '{'{1'b1, 3'd1, 3'd5, MODE_NET8}, '{1'b1, 3'd2, 3'd6, MODE_NET8},
      '{1'b0, 3'd0, 3'd0, MODE_NET8}, '{1'b0, 3'd0, 3'd0, MODE_NET8}},
    '{'{1'b1, 3'd2, 3'd4, MODE_NET8}, '{1'b1, 3'd3, 3'd5, MODE_NET8},
      '{1'b0, 3'd0, 3'd0, MODE_NET8}, '{1'b0, 3'd0, 3'd0, MODE_NET8}},
    '{'{1'b1, 3'd1, 3'd2, MODE_NET8}, '{1'b1, 3'd3, 3'd4, MODE_NET8},
      '{1'b1, 3'd5, 3'd6, MODE_NET8}, '{1'b0, 3'd0, 3'd0, MODE_NET8}}
  };

endpackage

`default_nettype wire

// ===== rtl/core/ssn8_if.sv =====
// ----------------------------------------------------------------------------
// ssn8_if
// Request and result channels of the sorting network, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface ssn8_in_if #(
  parameter int DATA_WIDTH = 32
);
  logic                               valid;
  logic                               ready;
  logic [ssn8_pkg::COUNT_W-1:0]       count;
  logic signed [DATA_WIDTH-1:0]       value_0;
  logic signed [DATA_WIDTH-1:0]       value_1;
  logic signed [DATA_WIDTH-1:0]       value_2;
  logic signed [DATA_WIDTH-1:0]       value_3;
  logic signed [DATA_WIDTH-1:0]       value_4;
  logic signed [DATA_WIDTH-1:0]       value_5;
  logic signed [DATA_WIDTH-1:0]       value_6;
  logic signed [DATA_WIDTH-1:0]       value_7;

  modport source (
    output valid, count, value_0, value_1, value_2, value_3,
           value_4, value_5, value_6, value_7,
    input  ready
  );
  modport sink (
    input  valid, count, value_0, value_1, value_2, value_3,
           value_4, value_5, value_6, value_7,
    output ready
  );
endinterface

interface ssn8_out_if #(
  parameter int DATA_WIDTH = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] sorted_0;
  logic signed [DATA_WIDTH-1:0] sorted_1;
  logic signed [DATA_WIDTH-1:0] sorted_2;
  logic signed [DATA_WIDTH-1:0] sorted_3;
  logic signed [DATA_WIDTH-1:0] sorted_4;
  logic signed [DATA_WIDTH-1:0] sorted_5;
  logic signed [DATA_WIDTH-1:0] sorted_6;
  logic signed [DATA_WIDTH-1:0] sorted_7;

  modport source (
    output valid, sorted_0, sorted_1, sorted_2, sorted_3,
           sorted_4, sorted_5, sorted_6, sorted_7,
    input  ready
  );
  modport sink (
    input  valid, sorted_0, sorted_1, sorted_2, sorted_3,
           sorted_4, sorted_5, sorted_6, sorted_7,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/core/ssn8_layer.sv =====
// ----------------------------------------------------------------------------
// ssn8_layer
// One registered layer of disjoint compare-exchange cells.
// ----------------------------------------------------------------------------
`default_nettype none

module ssn8_layer #(
  parameter int DATA_WIDTH = 32,
  parameter int LAYER      = 0
) (
  input  logic                                            clk,
  input  logic                                            rst_n,
  input  logic                                            advance,
  input  ssn8_pkg::ctl_t                                  ctl_in,
  input  logic [ssn8_pkg::NUM_LANES-1:0][DATA_WIDTH-1:0]  lanes_in,
  output ssn8_pkg::ctl_t                                  ctl_out,
  output logic [ssn8_pkg::NUM_LANES-1:0][DATA_WIDTH-1:0]  lanes_out
);

  ssn8_pkg::ctl_t                                  ctl_r;
  logic [ssn8_pkg::NUM_LANES-1:0][DATA_WIDTH-1:0]  lanes_r;
  logic [ssn8_pkg::NUM_LANES-1:0][DATA_WIDTH-1:0]  lanes_nxt;

  always_comb begin
    ssn8_pkg::cmp_t cmp;
    lanes_nxt = lanes_in;
    for (int c = 0; c < ssn8_pkg::MAX_CMP; c++) begin
      cmp = ssn8_pkg::LAYER_CMP[LAYER][c];
      if (cmp.en && (ctl_in.mode >= cmp.min_mode) &&
          ($signed(lanes_in[cmp.lo]) > $signed(lanes_in[cmp.hi]))) begin
        lanes_nxt[cmp.lo] = lanes_in[cmp.hi];
        lanes_nxt[cmp.hi] = lanes_in[cmp.lo];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.valid <= 1'b0;
      ctl_r.mode  <= ssn8_pkg::MODE_PASS;
    end else if (advance) begin
      ctl_r <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      lanes_r <= lanes_nxt;
    end
  end

  assign ctl_out   = ctl_r;
  assign lanes_out = lanes_r;

endmodule

`default_nettype wire

// ===== rtl/core/small_sorting_network_8_top.sv =====
// ----------------------------------------------------------------------------
// small_sorting_network_8_top
// Eight-lane signed sorting network with a count-selected width.
// ----------------------------------------------------------------------------
// Takes one request per cycle while the result side does not stall; each request
// passes the six comparator layers of the eight-lane odd-even merge network,
// each closed by a register. Count 1 or above 8 passes all lanes,
// 0 or 2 orders lanes 0..1, 3 or 4 sorts lanes 0..3, 5 to 8 sorts all lanes.
// Ties keep their lanes. When the result side stalls, the whole pipeline holds.
`default_nettype none

module small_sorting_network_8_top #(
  parameter int DATA_WIDTH = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  ssn8_in_if.sink      in_chan,
  ssn8_out_if.source   out_chan
);

  ssn8_pkg::ctl_t                                 ctl   [ssn8_pkg::NUM_LAYERS+1];
  logic [ssn8_pkg::NUM_LANES-1:0][DATA_WIDTH-1:0] lanes [ssn8_pkg::NUM_LAYERS+1];
  ssn8_pkg::mode_t                                mode;
  logic                                           advance;

  always_comb begin
    case (in_chan.count) inside
      4'd1:          mode = ssn8_pkg::MODE_PASS;
      [4'd0:4'd2]:   mode = ssn8_pkg::MODE_NET2;
      [4'd3:4'd4]:   mode = ssn8_pkg::MODE_NET4;
      [4'd5:4'd8]:   mode = ssn8_pkg::MODE_NET8;
      default:       mode = ssn8_pkg::MODE_PASS;
    endcase
  end

  assign advance = !ctl[ssn8_pkg::NUM_LAYERS].valid || out_chan.ready;

  assign in_chan.ready = advance;
  assign ctl[0].valid  = in_chan.valid;
  assign ctl[0].mode   = mode;
  assign lanes[0][0]   = in_chan.value_0;
  assign lanes[0][1]   = in_chan.value_1;
  assign lanes[0][2]   = in_chan.value_2;
  assign lanes[0][3]   = in_chan.value_3;
  assign lanes[0][4]   = in_chan.value_4;
  assign lanes[0][5]   = in_chan.value_5;
  assign lanes[0][6]   = in_chan.value_6;
  assign lanes[0][7]   = in_chan.value_7;

  for (genvar g = 0; g < ssn8_pkg::NUM_LAYERS; g++) begin : g_layer
    ssn8_layer #(
      .DATA_WIDTH (DATA_WIDTH),
      .LAYER      (g)
    ) u_layer (
      .clk       (clk),
      .rst_n     (rst_n),
      .advance   (advance),
      .ctl_in    (ctl[g]),
      .lanes_in  (lanes[g]),
      .ctl_out   (ctl[g+1]),
      .lanes_out (lanes[g+1])
    );
  end

  assign out_chan.valid    = ctl[ssn8_pkg::NUM_LAYERS].valid;
  assign out_chan.sorted_0 = lanes[ssn8_pkg::NUM_LAYERS][0];
  assign out_chan.sorted_1 = lanes[ssn8_pkg::NUM_LAYERS][1];
  assign out_chan.sorted_2 = lanes[ssn8_pkg::NUM_LAYERS][2];
  assign out_chan.sorted_3 = lanes[ssn8_pkg::NUM_LAYERS][3];
  assign out_chan.sorted_4 = lanes[ssn8_pkg::NUM_LAYERS][4];
  assign out_chan.sorted_5 = lanes[ssn8_pkg::NUM_LAYERS][5];
  assign out_chan.sorted_6 = lanes[ssn8_pkg::NUM_LAYERS][6];
  assign out_chan.sorted_7 = lanes[ssn8_pkg::NUM_LAYERS][7];

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the eight-lane count-selected sorting network.
// Requests with every count and with extreme, tied and random lanes go in
// through bursts with random gaps. Results come back under a changing
// backpressure pattern. Each request's lanes are run through an in-bench
// compare-exchange network, and every result is checked lane by lane, in order.
// ----------------------------------------------------------------------------
module tb_top;
  import ssn8_pkg::*;

  localparam int DW           = 32;
  localparam int LATENCY      = 6;
  localparam int RANDOM_REQS  = 1200;
  localparam int MAX_PRINTS   = 25;

  typedef logic [NUM_LANES-1:0][DW-1:0] lane_bus_t;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    lane_bus_t          values;
  } sort_req_t;

  localparam int BATCHER8 [19][2] = '{
    '{0, 1}, '{2, 3}, '{4, 5}, '{6, 7},
    '{0, 2}, '{1, 3}, '{4, 6}, '{5, 7},
    '{1, 2}, '{5, 6}, '{0, 4}, '{1, 5},
    '{2, 6}, '{3, 7}, '{2, 4}, '{3, 5},
    '{1, 2}, '{3, 4}, '{5, 6}
  };

  localparam int SORT4 [5][2] = '{'{0, 1}, '{2, 3}, '{0, 2}, '{1, 3}, '{1, 2}};

  class sort_checker;
    lane_bus_t expected_orders[$];
    int        errors;
    int        checked;
    int        by_mode[4];

    function new();
      errors  = 0;
      checked = 0;
      for (int i = 0; i < 4; i++) by_mode[i] = 0;
    endfunction

    static function mode_t mode_for_count(logic [COUNT_W-1:0] c);
      if (c == 1) return MODE_PASS;
      if (c <= 2) return MODE_NET2;
      if (c <= 4) return MODE_NET4;
      if (c <= 8) return MODE_NET8;
      return MODE_PASS;
    endfunction

    static function lane_bus_t order_pair(lane_bus_t v, int lo, int hi);
      logic [DW-1:0] t;
      if ($signed(v[lo]) > $signed(v[hi])) begin
        t     = v[lo];
        v[lo] = v[hi];
        v[hi] = t;
      end
      return v;
    endfunction

    static function lane_bus_t sort_by_count(sort_req_t r);
      lane_bus_t v;
      v = r.values;
      case (mode_for_count(r.count))
        MODE_NET2: begin
          v = order_pair(v, 0, 1);
        end
        MODE_NET4: begin
          for (int i = 0; i < 5; i++) v = order_pair(v, SORT4[i][0], SORT4[i][1]);
        end
        MODE_NET8: begin
          for (int i = 0; i < 19; i++) v = order_pair(v, BATCHER8[i][0], BATCHER8[i][1]);
        end
        default: begin
        end
      endcase
      return v;
    endfunction

    function int pending();
      return expected_orders.size();
    endfunction

    function void note_request(sort_req_t r);
      expected_orders.push_back(sort_by_count(r));
      by_mode[mode_for_count(r.count)]++;
    endfunction

    task report_mismatch(string what);
      if (errors < MAX_PRINTS) $display("[%0t] mismatch: %s", $realtime, what);
      errors++;
    endtask

    task check_result(lane_bus_t got);
      lane_bus_t want;
      if (expected_orders.size() == 0) begin
        report_mismatch("result with no request outstanding");
        return;
      end
      want = expected_orders.pop_front();
      checked++;
      for (int i = 0; i < NUM_LANES; i++) begin
        if (got[i] !== want[i])
          report_mismatch($sformatf("result %0d lane %0d: got %0d, want %0d",
                                    checked, i, $signed(got[i]), $signed(want[i])));
      end
    endtask
  endclass

  logic clk;
  logic rst_n;

  ssn8_in_if  #(.DATA_WIDTH(DW)) in_chan ();
  ssn8_out_if #(.DATA_WIDTH(DW)) out_chan ();

  small_sorting_network_8_top #(.DATA_WIDTH(DW)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  sort_checker book = new();

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #500000;
    $display("FAILURE");
    $finish;
  end

  function automatic logic [DW-1:0] extreme_lane();
    case ($urandom_range(0, 4))
      0: return {1'b1, {(DW-1){1'b0}}};
      1: return {1'b0, {(DW-1){1'b1}}};
      2: return '0;
      3: return '1;
      default: return DW'(1);
    endcase
  endfunction

  function automatic logic [DW-1:0] rand_lane();
    case ($urandom_range(0, 9))
      0: return {1'b1, {(DW-1){1'b0}}};
      1: return {1'b0, {(DW-1){1'b1}}};
      2, 3: return DW'(int'($urandom_range(0, 6)) - 3);
      default: return DW'($urandom);
    endcase
  endfunction

  function automatic logic [COUNT_W-1:0] rand_count();
    if ($urandom_range(0, 9) == 0) return COUNT_W'($urandom_range(9, 15));
    return COUNT_W'($urandom_range(0, 8));
  endfunction

  task automatic drive_request(sort_req_t r);
    in_chan.count   = r.count;
    in_chan.value_0 = r.values[0];
    in_chan.value_1 = r.values[1];
    in_chan.value_2 = r.values[2];
    in_chan.value_3 = r.values[3];
    in_chan.value_4 = r.values[4];
    in_chan.value_5 = r.values[5];
    in_chan.value_6 = r.values[6];
    in_chan.value_7 = r.values[7];
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic push_request(sort_req_t r);
    drive_request(r);
    in_chan.valid = 1'b1;
    do @(posedge clk); while (!in_chan.ready);
    book.note_request(r);
    @(negedge clk);
  endtask

  task automatic idle_for(int n);
    sort_req_t noise;
    in_chan.valid = 1'b0;
    repeat (n) begin
      noise.count = rand_count();
      for (int i = 0; i < NUM_LANES; i++) noise.values[i] = rand_lane();
      drive_request(noise);
      @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    in_chan.valid = 1'b0;
    while (book.pending() != 0) @(negedge clk);
  endtask

  // Sender
  initial begin
    sort_req_t r;
    sort_req_t directed_q[$];
    int        burst_left;

    rst_n         = 1'b0;
    in_chan.valid = 1'b0;
    r             = '0;
    drive_request(r);
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    for (int c = 0; c < 16; c++) begin
      r.count = COUNT_W'(c);
      for (int i = 0; i < NUM_LANES; i++) r.values[i] = extreme_lane();
      directed_q.push_back(r);
    end
    for (int i = 0; i < NUM_LANES; i++) r.values[i] = DW'(40 - 11 * i);
    r.count = 8;
    directed_q.push_back(r);
    r.count = 4;
    directed_q.push_back(r);
    r.count = 3;
    directed_q.push_back(r);
    for (int i = 0; i < NUM_LANES; i++) r.values[i] = DW'(-5);
    r.count = 8;
    directed_q.push_back(r);
    for (int i = 0; i < NUM_LANES; i++)
      r.values[i] = (i % 2 == 0) ? {1'b0, {(DW-1){1'b1}}} : {1'b1, {(DW-1){1'b0}}};
    directed_q.push_back(r);
    for (int i = 0; i < NUM_LANES; i++) r.values[i] = DW'(11 * i - 40);
    r.count = 5;
    directed_q.push_back(r);

    foreach (directed_q[k]) push_request(directed_q[k]);
    wait_drained();

    burst_left = 0;
    for (int n = 0; n < RANDOM_REQS; n++) begin
      if (n == RANDOM_REQS / 2) wait_drained();
      if (burst_left == 0) begin
        idle_for(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
        burst_left = $urandom_range(1, 40);
      end
      r.count = rand_count();
      for (int i = 0; i < NUM_LANES; i++) r.values[i] = rand_lane();
      push_request(r);
      burst_left--;
    end
    in_chan.valid = 1'b0;

    while (book.pending() != 0) @(posedge clk);
    repeat (2 * LATENCY) @(posedge clk);

    $display("Checked %0d sorted vectors: %0d pass-through, %0d two-lane, %0d four-lane, %0d eight-lane",
             book.checked, book.by_mode[MODE_PASS], book.by_mode[MODE_NET2],
             book.by_mode[MODE_NET4], book.by_mode[MODE_NET8]);
    $display("Counts 0 to 15 with extreme, tied and random lanes under bursts and stalls; %0d mismatches",
             book.errors);
    if (book.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Receiver: ready follows a 16-bit stall pattern reshuffled by a tick counter, often fully open
  initial begin
    logic [15:0] stall_pat;
    int          tick;
    out_chan.ready = 1'b0;
    stall_pat      = '1;
    tick           = 0;
    forever begin
      @(negedge clk);
      if (tick % 64 == 0)
        stall_pat = ($urandom_range(0, 2) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
      out_chan.ready = stall_pat[tick % 16];
      tick++;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready)
      book.check_result({out_chan.sorted_7, out_chan.sorted_6, out_chan.sorted_5,
                         out_chan.sorted_4, out_chan.sorted_3, out_chan.sorted_2,
                         out_chan.sorted_1, out_chan.sorted_0});
  end

endmodule

// ===== files.f =====
rtl/core/ssn8_pkg.sv
rtl/core/ssn8_if.sv
rtl/core/ssn8_layer.sv
rtl/core/small_sorting_network_8_top.sv
tb/sv/tb_top.sv
